// File: rtl/core/amacc_pkg.sv
// Shared constants, types and arithmetic helpers for the audio mix accumulator.
package amacc_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int SAMPLE_W     = 16;
    localparam int INDEX_W      = 6;
    localparam int VOLUME_W     = 11;
    localparam int OFFSET_W     = 6;
    localparam int ACC_W        = 32;
    localparam int PROD_W       = SAMPLE_W + VOLUME_W + 1;
    localparam int SUM_W        = INDEX_W + 1;
    localparam int CFG_DATA_W   = VOLUME_W;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VOLUME_W-1:0] VOLUME_RESET = VOLUME_W'(256);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

    localparam logic signed [ACC_W-1:0] CLAMP_MIN = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] CLAMP_MAX = ACC_W'(32767);

    // Request kinds
    localparam logic REQ_MIX   = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic CFG_VOLUME = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic              drain;
        logic [ADDR_W-1:0] addr;
        logic [ACC_W-1:0]  prod;
    } cmd_t;

    // Divide by 256 truncating toward zero, then clamp to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] scale_clamp(input logic [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] q;
        logic signed [SAMPLE_W-1:0] r;
        biased = $signed(v) + (v[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
        q = biased >>> 8;
        if (q < CLAMP_MIN)
            r = CLAMP_MIN[SAMPLE_W-1:0];
        else if (q > CLAMP_MAX)
            r = CLAMP_MAX[SAMPLE_W-1:0];
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/core/audio_mix_accumulator_core.sv
// A mix passes through the command queue; the back end then pops it and reads the accumulator, then writes the sum.
// The back end handles a mix as an accumulator read, then a write, and takes no new command before the write;
// a drain emits each entry as a memory read, then an output register load, which waits while the output stalls.
// The 4-entry command queue lets the input side run ahead of the back end.
// Reset clears valid bits, used length, queue and output; volume resets to 256, offset to 0.
// Top level: connects front end, command queue and back end.
module audio_mix_accumulator_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic signed [amacc_pkg::SAMPLE_W-1:0] sample,
    input  logic [amacc_pkg::INDEX_W-1:0]         sample_index,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [amacc_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                  last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [amacc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic            q_full;
    logic            q_push;
    amacc_pkg::cmd_t q_push_data;
    logic            q_pop;
    logic            q_valid;
    amacc_pkg::cmd_t q_pop_data;

    amacc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .sample       (sample),
        .sample_index (sample_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    amacc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_data  (q_pop_data)
    );

    amacc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .last       (last)
    );

endmodule

// File: rtl/core/amacc_front.sv
// Front end: configuration registers, request classification and product scaling.
module amacc_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic signed [amacc_pkg::SAMPLE_W-1:0] sample,
    input  logic [amacc_pkg::INDEX_W-1:0]      sample_index,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [amacc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output amacc_pkg::cmd_t                    q_data
);

    logic [amacc_pkg::VOLUME_W-1:0]     volume_reg;
    logic [amacc_pkg::VOLUME_W-1:0]     volume_next;
    logic [amacc_pkg::OFFSET_W-1:0]     offset_reg;
    logic [amacc_pkg::OFFSET_W-1:0]     offset_next;
    logic [amacc_pkg::SUM_W-1:0]        addr_full;
    logic                               in_range;
    logic signed [amacc_pkg::PROD_W-1:0] prod;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        volume_next = volume_reg;
        offset_next = offset_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                amacc_pkg::CFG_VOLUME: volume_next = cfg_data[amacc_pkg::VOLUME_W-1:0];
                amacc_pkg::CFG_OFFSET: offset_next = cfg_data[amacc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= amacc_pkg::VOLUME_RESET;
            offset_reg <= amacc_pkg::OFFSET_RESET;
        end
        else
        begin
            volume_reg <= volume_next;
            offset_reg <= offset_next;
        end
    end

    assign addr_full = amacc_pkg::SUM_W'(offset_reg) + amacc_pkg::SUM_W'(sample_index);
    assign in_range  = addr_full < amacc_pkg::SUM_W'(amacc_pkg::BUFFER_DEPTH);
    assign prod      = sample * $signed({1'b0, volume_reg});

    assign in_stall = q_full;

    // Drop mixes that land beyond the buffer; they are still accepted.
    assign q_push = in_valid && !q_full && ((req_type == amacc_pkg::REQ_DRAIN) || in_range);

    always_comb
    begin
        q_data.drain = (req_type == amacc_pkg::REQ_DRAIN);
        q_data.addr  = addr_full[amacc_pkg::ADDR_W-1:0];
        q_data.prod  = {{(amacc_pkg::ACC_W - amacc_pkg::PROD_W){prod[amacc_pkg::PROD_W-1]}}, prod};
    end

endmodule

// File: rtl/core/amacc_queue.sv
// Short command queue between the front end and the back end.
module amacc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  amacc_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output amacc_pkg::cmd_t pop_data
);

    amacc_pkg::cmd_t                entry_reg [amacc_pkg::QUEUE_DEPTH];
    logic [amacc_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [amacc_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [amacc_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [amacc_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [amacc_pkg::QCNT_W-1:0]   count_reg;
    logic [amacc_pkg::QCNT_W-1:0]   count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full     = (count_reg == amacc_pkg::QCNT_W'(amacc_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == amacc_pkg::QPTR_W'(amacc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + amacc_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == amacc_pkg::QPTR_W'(amacc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + amacc_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + amacc_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - amacc_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/core/amacc_back.sv
// Back end: accumulator memory, entry valid bits, mix sequencing and drain output.
module amacc_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  amacc_pkg::cmd_t                       q_data,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [amacc_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                  last
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_MIX_WR  = 4'b0010,
        ST_DRN_RD  = 4'b0100,
        ST_DRN_OUT = 4'b1000
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;
    amacc_pkg::cmd_t                       cmd_reg;
    amacc_pkg::cmd_t                       cmd_next;
    logic [amacc_pkg::ADDR_W-1:0]          k_reg;
    logic [amacc_pkg::ADDR_W-1:0]          k_next;
    logic [amacc_pkg::LEN_W-1:0]           used_len_reg;
    logic [amacc_pkg::LEN_W-1:0]           used_len_next;
    logic [amacc_pkg::BUFFER_DEPTH-1:0]    valid_reg;
    logic [amacc_pkg::BUFFER_DEPTH-1:0]    valid_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic signed [amacc_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic signed [amacc_pkg::SAMPLE_W-1:0] out_sample_next;
    logic                                  last_reg;
    logic                                  last_next;

    logic [amacc_pkg::ACC_W-1:0]           mem [amacc_pkg::BUFFER_DEPTH];
    logic                                  rd_en;
    logic [amacc_pkg::ADDR_W-1:0]          rd_addr;
    logic [amacc_pkg::ACC_W-1:0]           rd_data_reg;
    logic                                  hit_reg;
    logic                                  wr_en;
    logic [amacc_pkg::ADDR_W-1:0]          wr_addr;
    logic [amacc_pkg::ACC_W-1:0]           wr_data;

    logic [amacc_pkg::LEN_W-1:0]           addr_p1;
    logic                                  k_last;
    logic                                  out_free;

    assign addr_p1  = amacc_pkg::LEN_W'(cmd_reg.addr) + amacc_pkg::LEN_W'(1);
    assign k_last   = (amacc_pkg::LEN_W'(k_reg) + amacc_pkg::LEN_W'(1)) == used_len_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        k_next          = k_reg;
        used_len_next   = used_len_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        last_next       = last_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = k_reg;
        wr_en           = 1'b0;
        wr_addr         = cmd_reg.addr;
        wr_data         = cmd_reg.prod;

        // Release the output register once the result transfers.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    if (!q_data.drain)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = q_data.addr;
                        state_next = ST_MIX_WR;
                    end
                    else if (used_len_reg != '0)
                    begin
                        k_next     = '0;
                        state_next = ST_DRN_RD;
                    end
                end
            end
            ST_MIX_WR:
            begin
                // An entry not yet valid counts as zero: load the product.
                wr_en   = 1'b1;
                wr_data = hit_reg ? (rd_data_reg + cmd_reg.prod) : cmd_reg.prod;
                valid_next[cmd_reg.addr] = 1'b1;
                if (used_len_reg < addr_p1)
                    used_len_next = addr_p1;
                state_next = ST_IDLE;
            end
            ST_DRN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = ST_DRN_OUT;
            end
            ST_DRN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = amacc_pkg::scale_clamp(hit_reg ? rd_data_reg : '0);
                    last_next       = k_last;
                    if (k_last)
                    begin
                        valid_next    = '0;
                        used_len_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + amacc_pkg::ADDR_W'(1);
                        state_next = ST_DRN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            used_len_reg  <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            used_len_reg  <= used_len_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        out_sample_reg <= out_sample_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            hit_reg     <= valid_reg[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign last       = last_reg;

endmodule

// File: rtl/core/amacc_checker.sv
// Port-level checker for the audio mix accumulator, bound to the top level.
module amacc_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [amacc_pkg::SAMPLE_W-1:0] out_sample,
    input logic                                  last,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready
);

    // Hold a stalled result until it transfers.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_sample) && $stable(last))
        else $error("stalled result changed");

    // No result is presented while in reset.
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Configuration writes are never back-pressured.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind audio_mix_accumulator_core amacc_checker u_amacc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);

// File: verif/amacc_mix_checker.sv
// Mix buffer predictor and output checker for the audio mix accumulator testbench.
`timescale 1ns / 100ps

module amacc_mix_checker
    import amacc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       req_type,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [INDEX_W-1:0]         sample_index,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [SAMPLE_W-1:0] out_sample,
    input  logic                       last,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int unsigned                errors,
    output int unsigned                pending
);

    localparam int SCALE      = 256;
    localparam int CLAMP_HI   = 32767;
    localparam int CLAMP_LO   = -32768;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       tail;
    } drain_word_t;

    logic [VOLUME_W-1:0] gain;
    logic [OFFSET_W-1:0] offset;
    logic [ACC_W-1:0]    acc_mem [BUFFER_DEPTH];
    bit                  entry_live [BUFFER_DEPTH];
    int unsigned         fill_len;
    drain_word_t         drain_queue [$];
    int unsigned         fail_count = 0;

    assign errors = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic apply_config(input logic idx, input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_VOLUME)
            gain = data[VOLUME_W-1:0];
        else
            offset = data[OFFSET_W-1:0];
    endtask

    task automatic mix_into(input logic signed [SAMPLE_W-1:0] s,
                            input logic [INDEX_W-1:0] idx);
        logic [SUM_W-1:0]        addr;
        logic signed [ACC_W-1:0] s_wide;
        logic signed [ACC_W-1:0] g_wide;
        logic [ACC_W-1:0]        prod;
        addr   = SUM_W'(offset) + SUM_W'(idx);
        s_wide = s;
        g_wide = {{(ACC_W-VOLUME_W){1'b0}}, gain};
        prod   = s_wide * g_wide;
        // drop writes that land past the end of the buffer
        if (addr < BUFFER_DEPTH)
        begin
            acc_mem[addr]    = entry_live[addr] ? acc_mem[addr] + prod : prod;
            entry_live[addr] = 1'b1;
            if (fill_len < addr + 1)
                fill_len = addr + 1;
        end
    endtask

    task automatic drain_buffer();
        logic signed [ACC_W-1:0] v;
        logic signed [ACC_W-1:0] q;
        drain_word_t             w;
        int unsigned             k;
        for (k = 0; k < fill_len; k++)
        begin
            // entries skipped over by the fill count as zero
            v = entry_live[k] ? acc_mem[k] : '0;
            q = v / SCALE;
            if (q > CLAMP_HI)
                w.value = SAMPLE_W'(CLAMP_HI);
            else if (q < CLAMP_LO)
                w.value = SAMPLE_W'(CLAMP_LO);
            else
                w.value = q[SAMPLE_W-1:0];
            w.tail = (k + 1 == fill_len);
            drain_queue.push_back(w);
        end
        fill_len   = 0;
        entry_live = '{default: 1'b0};
    endtask

    task automatic check_word(input logic signed [SAMPLE_W-1:0] value, input logic tail);
        drain_word_t w;
        if (drain_queue.size() == 0)
            report_mismatch($sformatf("output %0d with no drain pending", value));
        else
        begin
            w = drain_queue.pop_front();
            if (value !== w.value)
                report_mismatch($sformatf("out_sample %0d, predicted %0d", value, w.value));
            if (tail !== w.tail)
                report_mismatch($sformatf("last %b, predicted %b (out_sample %0d)",
                                          tail, w.tail, w.value));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain       = VOLUME_RESET;
            offset     = OFFSET_RESET;
            entry_live = '{default: 1'b0};
            fill_len   = 0;
            drain_queue.delete();
            pending <= 0;
        end
        else
        begin
            // check the output first so a drain accepted on this edge cannot cover it
            if (out_valid && !out_stall)
                check_word(out_sample, last);
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_DRAIN)
                    drain_buffer();
                else
                    mix_into(sample, sample_index);
            end
            pending <= drain_queue.size();
        end
    end

endmodule

// File: verif/testbench.sv
// Top level of the audio mix accumulator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import amacc_pkg::*;

    localparam int ITEMS          = 330;
    localparam int SETTLE         = 24;
    localparam int DRAIN_TAIL     = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]         sample_index;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int unsigned errors;
    int unsigned pending;
    int unsigned items_sent  = 0;
    int unsigned idle_cycles = 0;
    bit          quiet       = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    audio_mix_accumulator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .sample       (sample),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_sample   (out_sample),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    amacc_mix_checker mix_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .sample       (sample),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_sample   (out_sample),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    // mostly short gaps, now and then a long one; none while quiet
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] s,
                             input logic [INDEX_W-1:0] idx);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        sample       <= s;
        sample_index <= idx;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_mix(input logic signed [SAMPLE_W-1:0] s, input logic [INDEX_W-1:0] idx);
        send_item(REQ_MIX, s, idx);
    endtask

    task automatic send_drain();
        send_item(REQ_DRAIN, pick_sample(), INDEX_W'($urandom));
    endtask

    // hold off until every predicted output is out and queued mixes have landed
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no drop in between
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [VOLUME_W-1:0] vol, input logic [OFFSET_W-1:0] off);
        logic [CFG_DATA_W-1:0] word;
        wait_idle();
        write_reg(CFG_VOLUME, vol);
        // junk in the unused upper bits of an offset write
        word = CFG_DATA_W'($urandom);
        word[OFFSET_W-1:0] = off;
        write_reg(CFG_OFFSET, word);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned gap;
        out_stall <= 1'b0;
        forever
        begin
            gap = gap_len();
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("audio_mix_accumulator_core regression: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned nblocks;
        int unsigned len;
        logic [VOLUME_W-1:0] vol;
        logic [OFFSET_W-1:0] off;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        req_type     <= REQ_MIX;
        sample       <= '0;
        sample_index <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_VOLUME;
        cfg_data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gain and offset: empty drain, full-scale samples, zero fill, top entry
        send_drain();
        send_mix(16'sh7FFF, 0);
        send_mix(16'sh8000, 1);
        send_mix(0, 2);
        send_mix(1, 5);
        send_mix(-1, 63);
        send_drain();
        send_drain();

        // smallest nonzero gain: truncation toward zero on both signs
        set_config(1, 0);
        send_mix(-255, 0);
        send_mix(-257, 1);
        send_mix(255, 2);
        send_mix(16'sh7FFF, 3);
        send_drain();

        // offset at the top: one live entry, the rest dropped past the end
        set_config(1024, 63);
        send_mix(16'sh7FFF, 0);
        send_mix(16'sh7FFF, 1);
        send_mix(16'sh8000, 63);
        send_drain();

        // largest gain: clamp at both ends
        set_config(2047, 0);
        send_mix(16'sh8000, 0);
        send_mix(16'sh7FFF, 1);
        send_drain();

        // zero gain still marks the entry written
        set_config(0, 5);
        send_mix(12345, 0);
        send_drain();

        phase = 0;
        while (items_sent < ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       vol = 0;
                1:       vol = 2047;
                2:       vol = 1024;
                3:       vol = 256;
                default: vol = VOLUME_W'($urandom_range(0, 2047));
            endcase
            case ($urandom_range(0, 3))
                0:       off = 0;
                1:       off = 63;
                default: off = OFFSET_W'($urandom_range(0, 40));
            endcase
            if (phase == 2)
            begin
                // pile loud samples onto two entries until the sums wrap
                set_config(2047, 0);
                repeat (70) send_mix(SAMPLE_W'($urandom_range(28000, 32767)),
                                     INDEX_W'($urandom_range(0, 1)));
            end
            else
            begin
                set_config(vol, off);
                quiet   = (phase % 4 == 3);
                nblocks = $urandom_range(1, 4);
                for (int b = 0; b < nblocks; b++)
                begin
                    len = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_mix(pick_sample(), INDEX_W'($urandom));
                        else
                            send_mix(pick_sample(), INDEX_W'(i));
                    end
                    if ($urandom_range(0, 3) == 0)
                        send_drain();
                    if (phase == 1 && b == 0)
                    begin
                        send_drain();
                        wait_idle();
                    end
                end
            end
            send_drain();
            quiet = 1'b0;
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (errors == 0)
            $display("audio_mix_accumulator_core regression: pass");
        else
            $display("audio_mix_accumulator_core regression: fail");
        $finish;
    end

endmodule
